// ===== rtl/core/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, token codes and helper functions for the shunting-yard
// infix to postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

    // Default operator stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // Field widths
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 32;
    localparam int LINE_W  = 16;
    localparam int ERR_W   = 2;
    localparam int PREC_W  = 2;

    // Token kind codes
    localparam logic [KIND_W-1:0] K_OPERAND = 4'd0;
    localparam logic [KIND_W-1:0] K_LPAREN  = 4'd1;
    localparam logic [KIND_W-1:0] K_RPAREN  = 4'd2;
    localparam logic [KIND_W-1:0] K_ADD     = 4'd3;
    localparam logic [KIND_W-1:0] K_SUB     = 4'd4;
    localparam logic [KIND_W-1:0] K_MUL     = 4'd5;
    localparam logic [KIND_W-1:0] K_DIV     = 4'd6;
    localparam logic [KIND_W-1:0] K_EQ      = 4'd7;
    localparam logic [KIND_W-1:0] K_NE      = 4'd8;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 4'd9;
    localparam logic [KIND_W-1:0] K_SEMI    = 4'd10;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNBAL    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

    // Precedence levels
    localparam logic [PREC_W-1:0] PREC_LOW = 2'd0;
    localparam logic [PREC_W-1:0] PREC_ADD = 2'd2;
    localparam logic [PREC_W-1:0] PREC_MUL = 2'd3;

    // One operator stack entry
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [LINE_W-1:0]  line;
    } t_entry;

    // Token class, decoded once at accept
    typedef enum logic [2:0] {
        CLS_PASS,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER,
        CLS_SEMI
    } t_cls;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_EVAL,
        ST_END
    } t_state;

    function automatic t_cls classify(input logic [KIND_W-1:0] kind);
        t_cls cls;
        case (kind) inside
            K_LPAREN:                                           cls = CLS_OPEN;
            K_RPAREN:                                           cls = CLS_CLOSE;
            K_ADD, K_SUB, K_MUL, K_DIV, K_EQ, K_NE, K_ASSIGN:   cls = CLS_OPER;
            K_SEMI:                                             cls = CLS_SEMI;
            default:                                            cls = CLS_PASS;
        endcase
        return cls;
    endfunction

    // Only '(' and operators ever reach the stack; other kinds never get compared
    function automatic logic [PREC_W-1:0] prec_of(input logic [KIND_W-1:0] kind);
        logic [PREC_W-1:0] p;
        case (kind) inside
            K_LPAREN, K_ASSIGN:         p = PREC_LOW;
            K_ADD, K_SUB, K_EQ, K_NE:   p = PREC_ADD;
            default:                    p = PREC_MUL;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/infix_to_postfix_converter_top.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: reorders a lexed token stream into postfix order
// using an operator stack held in a single-port style memory.
// ----------------------------------------------------------------------------
// One token is handled at a time and the input stalls until it is done.
// An operand, a '(' or a token that meets an empty stack passes through
// accept, decode and finish. Otherwise the stack memory gives one registered
// read per cycle while the output is not stalled, and each read decides the
// next pop; every popped entry is read, as is the entry that stops the pops
// when the stack is not run empty. A ')' that runs the stack empty or a ';'
// after pops gives one more, trailing result after the last pop. Output
// stall holds the sequence. The stack resets empty; a ';' emits every
// open entry and then an end-of-line marker with o_last set. o_last marks
// the final result of each token, and error results (unbalanced ')' or
// stack overflow) always carry o_last.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // token request in
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [i2p_pkg::KIND_W-1:0]   i_token_kind,
    input  logic [i2p_pkg::VALUE_W-1:0]  i_token_value,
    input  logic [i2p_pkg::LINE_W-1:0]   i_line_number,
    // result request out
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [i2p_pkg::KIND_W-1:0]   o_out_kind,
    output logic [i2p_pkg::VALUE_W-1:0]  o_out_value,
    output logic [i2p_pkg::LINE_W-1:0]   o_out_line,
    output logic [i2p_pkg::ERR_W-1:0]    o_error_code,
    output logic                         o_last
);
    import i2p_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Sequencer and token registers
    t_state              r_state, n_state;
    t_cls                r_cls;
    logic [PREC_W-1:0]   r_prec;
    logic [KIND_W-1:0]   r_kind;
    logic [VALUE_W-1:0]  r_value;
    logic [LINE_W-1:0]   r_line;
    logic [CW-1:0]       r_count, n_count;

    // Popped entry held until we know whether it is the last result
    t_entry              r_pend, n_pend;
    logic                r_pend_v, n_pend_v;

    // Stack memory
    t_entry              r_mem [STACK_DEPTH];
    t_entry              r_rd;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    t_entry              mem_wdata;

    // Output register
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    logic [VALUE_W-1:0]  r_out_value;
    logic [LINE_W-1:0]   r_out_line;
    logic [ERR_W-1:0]    r_out_err;
    logic                r_out_last;

    logic                emit;
    logic [KIND_W-1:0]   em_kind;
    logic [VALUE_W-1:0]  em_value;
    logic [LINE_W-1:0]   em_line;
    logic [ERR_W-1:0]    em_err;
    logic                em_last;

    logic                in_accept;
    logic                out_free;
    logic                pop_ok;
    logic                stack_full;
    logic                stack_empty;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign stack_full  = (r_count == CW'(STACK_DEPTH));
    assign stack_empty = (r_count == '0);
    assign o_in_stall  = (r_state != ST_IDLE);

    // Pop decision on the freshly read top entry
    always_comb begin
        case (r_cls)
            CLS_OPER:  pop_ok = (prec_of(r_rd.kind) >= r_prec);
            CLS_CLOSE: pop_ok = (r_rd.kind != K_LPAREN);
            CLS_SEMI:  pop_ok = 1'b1;
            default:   pop_ok = 1'b0;
        endcase
    end

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    // Token and pending-entry payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_token_kind;
            r_value <= i_token_value;
            r_line  <= i_line_number;
            r_cls   <= classify(i_token_kind);
            r_prec  <= prec_of(i_token_kind);
        end
        r_pend <= n_pend;
    end

    // Next state, stack access and result selection
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_count);
        mem_wdata = '{kind: r_kind, value: r_value, line: r_line};
        mem_re    = 1'b0;
        mem_raddr = AW'(r_count - CW'(1));
        emit      = 1'b0;
        em_kind   = r_pend.kind;
        em_value  = r_pend.value;
        em_line   = r_pend.line;
        em_err    = ERR_NONE;
        em_last   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state  = ST_START;
                    n_pend_v = 1'b0;
                end
            end

            ST_START: begin
                if (r_cls == CLS_PASS || r_cls == CLS_OPEN || stack_empty) begin
                    n_state = ST_END;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_EVAL;
                end
            end

            ST_EVAL: begin
                if (!pop_ok) begin
                    n_state = ST_END;
                end else if (!r_pend_v || out_free) begin
                    // earlier pop is now known not to be last
                    emit     = r_pend_v;
                    n_pend   = r_rd;
                    n_pend_v = 1'b1;
                    n_count  = r_count - CW'(1);
                    if (r_count != CW'(1)) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_count - CW'(2));
                    end else begin
                        n_state = ST_END;
                    end
                end
            end

            ST_END: begin
                unique case (r_cls)
                    CLS_PASS: begin
                        em_kind  = r_kind;
                        em_value = r_value;
                        em_line  = r_line;
                        em_last  = 1'b1;
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end

                    CLS_OPEN, CLS_OPER: begin
                        if (r_pend_v) begin
                            // pops leave room, so the push always fits
                            em_last = 1'b1;
                            if (out_free) begin
                                emit     = 1'b1;
                                n_pend_v = 1'b0;
                                mem_we   = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_state  = ST_IDLE;
                            end
                        end else if (stack_full) begin
                            em_kind  = r_kind;
                            em_value = r_value;
                            em_line  = r_line;
                            em_err   = ERR_OVERFLOW;
                            em_last  = 1'b1;
                            if (out_free) begin
                                emit    = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_state = ST_IDLE;
                        end
                    end

                    CLS_CLOSE: begin
                        if (!stack_empty) begin
                            // matching '(' on top: drop it
                            em_last = 1'b1;
                            if (!r_pend_v || out_free) begin
                                emit     = r_pend_v;
                                n_pend_v = 1'b0;
                                n_count  = r_count - CW'(1);
                                n_state  = ST_IDLE;
                            end
                        end else if (r_pend_v) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                n_pend_v = 1'b0;
                            end
                        end else begin
                            em_kind  = r_kind;
                            em_value = r_value;
                            em_line  = r_line;
                            em_err   = ERR_UNBAL;
                            em_last  = 1'b1;
                            if (out_free) begin
                                emit    = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                    end

                    CLS_SEMI: begin
                        if (r_pend_v) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                n_pend_v = 1'b0;
                            end
                        end else begin
                            // end-of-line marker
                            em_kind  = K_SEMI;
                            em_value = '0;
                            em_line  = r_line;
                            em_last  = 1'b1;
                            if (out_free) begin
                                emit    = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                    end
                endcase
            end
        endcase
    end

    // Stack memory write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Stack memory registered read port
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind  <= em_kind;
            r_out_value <= em_value;
            r_out_line  <= em_line;
            r_out_err   <= em_err;
            r_out_last  <= em_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_value  = r_out_value;
    assign o_out_line   = r_out_line;
    assign o_error_code = r_out_err;
    assign o_last       = r_out_last;

    // Assertions
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !stack_full)
        else $error("push into full stack");

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending entry left over at idle");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != ERR_NONE) |-> o_last)
        else $error("error result without last");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_START))
        else $error("accepted token not started");

endmodule
